// File: rtl/sks_pkg.sv
package sks_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_DUP      = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_INS_SH,
    ST_INS_WR,
    ST_REM_SH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   key_count;
  } result_t;

endpackage

// File: rtl/sorted_key_set_insert_remove.sv
// Channel   Ports                   Handshake
// -------   ---------------------   ---------------------------------------
// request   start, busy, cmd        taken at an edge with start high, busy low
// result    done, result            valid for one cycle while done is high
//
// The search reads one entry per cycle up to the sorted position p, n being
// the keys stored; an insert then shifts the n - p entries from p upward up,
// a remove the n - p - 1 entries above p down, one per cycle over the single
// table write port. Busy drops the cycle after the result.
// Reset empties the set at once; table contents need no clearing.
// The result receiver cannot stall; busy stays high until the result is shown.
module sorted_key_set_insert_remove #(
  parameter int unsigned CAPACITY = sks_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sks_pkg::request_t cmd,
  output logic              busy,
  output logic              done,
  output sks_pkg::result_t  result
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sks_pkg::state_t  state, state_next;
  sks_pkg::request_t req;
  sks_pkg::status_t status, status_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    cur, cur_next;
  logic [CW-1:0]    pos, pos_next;
  logic             found, found_next;

  logic [sks_pkg::KEY_W-1:0] mem [CAPACITY];
  logic [sks_pkg::KEY_W-1:0] rd_data;
  logic [AW-1:0]             rd_addr;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [sks_pkg::KEY_W-1:0] wd;

  logic key_less;
  logic key_eq;

  assign key_less = $signed(rd_data) < $signed(req.key);
  assign key_eq   = rd_data == req.key;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sks_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= cmd;
    end
    status <= status_next;
    cur    <= cur_next;
    pos    <= pos_next;
    found  <= found_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sks_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (cnt == '0) ? sks_pkg::ST_DECIDE : sks_pkg::ST_SEARCH;
        end
      end
      sks_pkg::ST_SEARCH: begin
        if (!key_less || (cur + CW'(1) == cnt)) begin
          state_next = sks_pkg::ST_DECIDE;
        end
      end
      sks_pkg::ST_DECIDE: begin
        if (req.mode == sks_pkg::MODE_INSERT) begin
          if (found || cnt == CW'(CAPACITY)) begin
            state_next = sks_pkg::ST_RESP;
          end else if (cnt == pos) begin
            state_next = sks_pkg::ST_INS_WR;
          end else begin
            state_next = sks_pkg::ST_INS_SH;
          end
        end else begin
          if (!found || (pos + CW'(1) == cnt)) begin
            state_next = sks_pkg::ST_RESP;
          end else begin
            state_next = sks_pkg::ST_REM_SH;
          end
        end
      end
      sks_pkg::ST_INS_SH: begin
        if (cur - CW'(1) == pos) begin
          state_next = sks_pkg::ST_INS_WR;
        end
      end
      sks_pkg::ST_INS_WR: state_next = sks_pkg::ST_RESP;
      sks_pkg::ST_REM_SH: begin
        if (cur + CW'(2) == cnt) begin
          state_next = sks_pkg::ST_RESP;
        end
      end
      sks_pkg::ST_RESP: state_next = sks_pkg::ST_IDLE;
      default: state_next = sks_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = state != sks_pkg::ST_IDLE;
    done        = state == sks_pkg::ST_RESP;
    result.status    = status;
    result.key_count = sks_pkg::COUNT_W'(cnt);
    status_next = status;
    cnt_next    = cnt;
    cur_next    = cur;
    pos_next    = pos;
    found_next  = found;
    rd_addr     = AW'(cur);
    we          = 1'b0;
    wa          = AW'(cur);
    wd          = rd_data;
    unique case (state)
      sks_pkg::ST_IDLE: begin
        // prime the read of the first entry
        rd_addr    = '0;
        cur_next   = '0;
        pos_next   = '0;
        found_next = 1'b0;
      end
      sks_pkg::ST_SEARCH: begin
        if (key_less) begin
          if (cur + CW'(1) == cnt) begin
            pos_next   = cnt;
            found_next = 1'b0;
          end else begin
            cur_next = cur + CW'(1);
            rd_addr  = AW'(cur + CW'(1));
          end
        end else begin
          pos_next   = cur;
          found_next = key_eq;
        end
      end
      sks_pkg::ST_DECIDE: begin
        if (req.mode == sks_pkg::MODE_INSERT) begin
          if (found) begin
            status_next = sks_pkg::STATUS_DUP;
          end else if (cnt == CW'(CAPACITY)) begin
            status_next = sks_pkg::STATUS_FULL;
          end else if (cnt != pos) begin
            rd_addr  = AW'(cnt - CW'(1));
            cur_next = cnt;
          end
        end else begin
          if (!found) begin
            status_next = sks_pkg::STATUS_NOTFOUND;
          end else if (pos + CW'(1) == cnt) begin
            status_next = sks_pkg::STATUS_DONE;
            cnt_next    = cnt - CW'(1);
          end else begin
            rd_addr  = AW'(pos + CW'(1));
            cur_next = pos;
          end
        end
      end
      sks_pkg::ST_INS_SH: begin
        // move entry cur-1 up to cur, fetch the next one down
        we       = 1'b1;
        wa       = AW'(cur);
        wd       = rd_data;
        rd_addr  = AW'(cur - CW'(2));
        cur_next = cur - CW'(1);
      end
      sks_pkg::ST_INS_WR: begin
        we          = 1'b1;
        wa          = AW'(pos);
        wd          = req.key;
        cnt_next    = cnt + CW'(1);
        status_next = sks_pkg::STATUS_DONE;
      end
      sks_pkg::ST_REM_SH: begin
        // move entry cur+1 down to cur, fetch the next one up
        we       = 1'b1;
        wa       = AW'(cur);
        wd       = rd_data;
        rd_addr  = AW'(cur + CW'(2));
        cur_next = cur + CW'(1);
        if (cur + CW'(2) == cnt) begin
          cnt_next    = cnt - CW'(1);
          status_next = sks_pkg::STATUS_DONE;
        end
      end
      sks_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("key count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result not followed by idle");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && result.status == sks_pkg::STATUS_FULL |-> cnt == CW'(CAPACITY))
    else $error("full reported on a table that is not full");

endmodule
